[src/tse_pkg.sv]
// ----------------------------------------------------------------------------
// tse_pkg
// Constants for the text encoding sniffer: UTF-8 lead byte ranges,
// byte-order mark bytes and the encoding codes reported with each file.
// ----------------------------------------------------------------------------
package tse_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_UTF8  = 2'd0;
  localparam kind_t KIND_U16LE = 2'd1;
  localparam kind_t KIND_U16BE = 2'd2;
  localparam kind_t KIND_EUCKR = 2'd3;

  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam logic [7:0] HIGH_FIRST = 8'h80;

  localparam logic [7:0] BOM_FF = 8'hFF;
  localparam logic [7:0] BOM_FE = 8'hFE;
  localparam logic [7:0] BOM_EF = 8'hEF;
  localparam logic [7:0] BOM_BB = 8'hBB;
  localparam logic [7:0] BOM_BF = 8'hBF;

endpackage

[src/text_encoding_sniffer.sv]
// ----------------------------------------------------------------------------
// text_encoding_sniffer
// Byte-serial detector of UTF-8 validity and byte-order marks.
// ----------------------------------------------------------------------------
// Usage: a file streams in on the input channel (in_valid / in_ready), one
// byte per transaction, with final_byte set on its last byte. Only the
// transaction that carries final_byte produces an output transaction
// (out_valid / out_ready): the detected encoding, the count of well formed
// UTF-8 multibyte sequences and the count of high bytes in none of them.
// The scan state clears as the final byte leaves the input register, so the
// next byte starts a new file.
//
// An accepted byte is held in the input register; the scanner updates its
// state from it and, for a final byte, loads the result register, which
// raises out_valid. A final byte waits in the input register while an
// earlier result is still held and out_ready is low.
// Throughput is one byte per cycle while no final byte waits there, set by
// the single state update between the input register and the result register.
//
// Reset (rst, synchronous, active high) clears the scan state, counters and
// both valid flags. If the receiver stalls while a result waits, non-final
// bytes keep flowing through the scanner; a second final byte waits in the
// input register, and in_ready drops only once that register is also held.
// ----------------------------------------------------------------------------
module text_encoding_sniffer #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       data_byte,
  input  logic             final_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output tse_pkg::kind_t   encoding_kind,
  output logic [31:0]      valid_sequences,
  output logic [31:0]      invalid_high_bytes
);
  import tse_pkg::*;

  // Input register.
  logic       in_q_valid;
  logic [7:0] byte_q;
  logic       final_q;

  // Scan state.
  logic [23:0]            lead_bytes, lead_bytes_next;
  logic [1:0]             seen, seen_next;
  logic [2:0]             pend_len, pend_len_next;
  logic [1:0]             pend_cont, pend_cont_next;
  logic [COUNT_WIDTH-1:0] valid_count, valid_count_next;
  logic [COUNT_WIDTH-1:0] invalid_count, invalid_count_next;

  // Per-byte results.
  logic                   adv;
  logic [COUNT_WIDTH-1:0] valid_sat, invalid_sat;
  kind_t                  kind;

  // The input register moves on unless it holds a final byte while the
  // result register is still occupied.
  assign adv      = in_q_valid && (!final_q || !out_valid || out_ready);
  assign in_ready = !in_q_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      byte_q  <= data_byte;
      final_q <= final_byte;
    end
  end

  // One byte of scanning: byte-order mark capture, the open sequence, and
  // saturating counter updates. A final byte also flushes a cut-off sequence
  // and clears the state for the next file.
  always_comb begin
    logic                 is_cont;
    logic [2:0]           pl;
    logic [1:0]           pc;
    logic [1:0]           pc_inc;
    logic [2:0]           inv_add;
    logic                 val_inc;
    logic [COUNT_WIDTH:0] vsum;
    logic [COUNT_WIDTH:0] isum;
    logic [7:0]           b0, b1, b2;

    lead_bytes_next = lead_bytes;
    seen_next       = seen;
    if (seen != 2'd3) begin
      case (seen)
        2'd0:    lead_bytes_next[23:16] = byte_q;
        2'd1:    lead_bytes_next[15:8]  = byte_q;
        default: lead_bytes_next[7:0]   = byte_q;
      endcase
      seen_next = seen + 2'd1;
    end

    is_cont = (byte_q & CONT_MASK) == CONT_CODE;
    pl      = pend_len;
    pc      = pend_cont;
    pc_inc  = pend_cont + 2'd1;
    inv_add = 3'd0;
    val_inc = 1'b0;

    if (pend_len != 3'd0 && is_cont) begin
      if (({1'b0, pc_inc} + 3'd1) >= pend_len) begin
        val_inc = 1'b1;
        pl      = 3'd0;
        pc      = 2'd0;
      end else begin
        pc = pc_inc;
      end
    end else begin
      // A broken sequence charges the lead and each buffered continuation,
      // then the failing byte is looked at on its own.
      if (pend_len != 3'd0) begin
        inv_add = 3'd1 + {1'b0, pend_cont};
      end
      pl = 3'd0;
      pc = 2'd0;
      if (byte_q >= HIGH_FIRST) begin
        case (byte_q) inside
          [LEAD2_LO:LEAD2_HI]: pl = 3'd2;
          [LEAD3_LO:LEAD3_HI]: pl = 3'd3;
          [LEAD4_LO:LEAD4_HI]: pl = 3'd4;
          default:             inv_add = inv_add + 3'd1;
        endcase
      end
    end

    // A sequence still open at the end of the file counts as broken.
    if (final_q && pl != 3'd0) begin
      inv_add = inv_add + 3'd1 + {1'b0, pc};
    end

    vsum = {1'b0, valid_count} + (COUNT_WIDTH+1)'(val_inc);
    isum = {1'b0, invalid_count} + (COUNT_WIDTH+1)'(inv_add);
    valid_sat   = vsum[COUNT_WIDTH] ? '1 : vsum[COUNT_WIDTH-1:0];
    invalid_sat = isum[COUNT_WIDTH] ? '1 : isum[COUNT_WIDTH-1:0];

    b0 = lead_bytes_next[23:16];
    b1 = lead_bytes_next[15:8];
    b2 = lead_bytes_next[7:0];
    if (seen_next == 2'd3 && b0 == BOM_EF && b1 == BOM_BB && b2 == BOM_BF) begin
      kind = KIND_UTF8;
    end else if (seen_next >= 2'd2 && b0 == BOM_FF && b1 == BOM_FE) begin
      kind = KIND_U16LE;
    end else if (seen_next >= 2'd2 && b0 == BOM_FE && b1 == BOM_FF) begin
      kind = KIND_U16BE;
    end else if (invalid_sat != '0) begin
      kind = KIND_EUCKR;
    end else begin
      kind = KIND_UTF8;
    end

    if (final_q) begin
      lead_bytes_next    = '0;
      seen_next          = 2'd0;
      pend_len_next      = 3'd0;
      pend_cont_next     = 2'd0;
      valid_count_next   = '0;
      invalid_count_next = '0;
    end else begin
      pend_len_next      = pl;
      pend_cont_next     = pc;
      valid_count_next   = valid_sat;
      invalid_count_next = invalid_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_bytes    <= '0;
      seen          <= 2'd0;
      pend_len      <= 3'd0;
      pend_cont     <= 2'd0;
      valid_count   <= '0;
      invalid_count <= '0;
    end else if (adv) begin
      lead_bytes    <= lead_bytes_next;
      seen          <= seen_next;
      pend_len      <= pend_len_next;
      pend_cont     <= pend_cont_next;
      valid_count   <= valid_count_next;
      invalid_count <= invalid_count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && final_q) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (adv && final_q) begin
      encoding_kind      <= kind;
      valid_sequences    <= 32'(valid_sat);
      invalid_high_bytes <= 32'(invalid_sat);
    end
  end

`ifndef NO_ASSERTIONS
  // An open sequence always has room for at least one more continuation.
  a_pend_room: assert property (@(posedge clk) disable iff (rst)
    pend_len != 3'd0 |-> ({1'b0, pend_cont} + 3'd1) < pend_len)
    else $error("open sequence holds too many continuations");

  // The end of a file leaves the scanner in its reset state.
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    adv && final_q |=> pend_len == 3'd0 && seen == 2'd0 &&
                       valid_count == '0 && invalid_count == '0)
    else $error("scan state not cleared after final byte");

  // A final byte that leaves the input register always yields a result.
  a_final_result: assert property (@(posedge clk) disable iff (rst)
    adv && final_q |=> out_valid)
    else $error("final byte produced no result");

  // The input register only holds while a result waits for the receiver.
  a_hold_reason: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !adv |-> out_valid && !out_ready)
    else $error("input register stalled without a waiting result");
`endif

endmodule
